// ===== rtl/lfp_pkg.sv =====
package lfp_pkg;

  localparam logic [7:0]  HDR_BYTE            = 8'h59;
  localparam int unsigned PAYLOAD_LEN         = 5;
  localparam int unsigned CNT_W               = 3;
  localparam logic [CNT_W-1:0] LAST_CNT       = CNT_W'(PAYLOAD_LEN - 1);

  localparam int unsigned CFG_IDX_W           = 2;
  localparam int unsigned CFG_DATA_W          = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH_MAX = 2'd1;

  localparam logic [15:0] STRENGTH_MIN_RESET  = 16'd20;
  localparam logic [15:0] STRENGTH_MAX_RESET  = 16'd2000;

  typedef enum logic [1:0] {
    HUNT_IDLE    = 2'd0,
    HUNT_FIRST   = 2'd1,
    HUNT_CAPTURE = 2'd2
  } hunt_t;

endpackage

// ===== rtl/lidar_frame_parser.sv =====
// Frame parser for a laser range sensor serial stream. One received byte is
// taken per transfer on the in_ channel, and a new byte can be taken every
// cycle while in_stall is low. The parser hunts for the header pair 0x59
// 0x59 (a non-header byte after the first header returns to hunting and is
// not rechecked), then captures distance low/high, strength low/high and
// the mode byte. The mode byte completes the frame and produces one result
// transfer on the out_ channel; every other byte produces none. A result
// appears once the mode byte has passed the input register and the parse
// logic has loaded the result register. The distance is accepted when
// strength_min < strength < strength_max (cfg index 0 and 1, reset 20 and
// 2000); the last accepted distance is held and reported with every result.
// The input side only stalls while a result waits in the output register
// and the next byte is ready to be parsed. Write the configuration only
// while no bytes are in flight.
module lidar_frame_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [15:0]                   out_frame_distance,
  output logic [15:0]                   out_frame_strength,
  output logic [7:0]                    out_range_mode,
  output logic                          out_accepted,
  output logic [15:0]                   out_held_distance_out,
  input  logic                          cfg_wr_en,
  input  logic [lfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lfp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lfp_pkg::*;

  // configuration
  logic [15:0] strength_min_r;
  logic [15:0] strength_max_r;

  // input register stage
  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic [7:0]  s1_byte_r;

  // parser state
  hunt_t           hunt_r;
  hunt_t           hunt_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [7:0]      payload_r [4];
  logic [15:0]     held_r;
  logic [15:0]     held_nxt;

  // result register
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [15:0] out_dist_r;
  logic [15:0] out_str_r;
  logic [7:0]  out_mode_r;
  logic        out_ok_r;
  logic [15:0] out_held_r;

  logic        blocked;
  logic        fire;
  logic        frame_done;
  logic        store_byte;
  logic [15:0] frame_dist;
  logic [15:0] strength;
  logic        ok;

  // A waiting result blocks the parse stage; hold the input register then.
  assign blocked  = out_valid_r && out_stall;
  assign fire     = s1_valid_r && !blocked;
  assign in_stall = s1_valid_r && blocked;

  assign frame_dist = {payload_r[1], payload_r[0]};
  assign strength   = {payload_r[3], payload_r[2]};
  assign ok         = (strength > strength_min_r) && (strength < strength_max_r);

  // Next-state logic of the header hunt and payload capture.
  always_comb begin
    hunt_nxt   = hunt_r;
    count_nxt  = count_r;
    held_nxt   = held_r;
    frame_done = 1'b0;
    store_byte = 1'b0;
    if (fire) begin
      case (hunt_r)
        HUNT_CAPTURE: begin
          if (count_r >= LAST_CNT) begin
            // mode byte: close the frame
            frame_done = 1'b1;
            hunt_nxt   = HUNT_IDLE;
            count_nxt  = '0;
            if (ok) begin
              held_nxt = frame_dist;
            end
          end else begin
            store_byte = 1'b1;
            count_nxt  = count_r + 1'b1;
          end
        end
        HUNT_FIRST: begin
          if (s1_byte_r == HDR_BYTE) begin
            hunt_nxt  = HUNT_CAPTURE;
            count_nxt = '0;
          end else begin
            // drop back without rechecking this byte
            hunt_nxt = HUNT_IDLE;
          end
        end
        default: begin
          hunt_nxt = (s1_byte_r == HDR_BYTE) ? HUNT_FIRST : HUNT_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
    end
    out_valid_nxt = out_valid_r && out_stall;
    if (frame_done) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strength_min_r <= STRENGTH_MIN_RESET;
      strength_max_r <= STRENGTH_MAX_RESET;
      s1_valid_r     <= 1'b0;
      hunt_r         <= HUNT_IDLE;
      count_r        <= '0;
      held_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_STRENGTH_MIN: strength_min_r <= cfg_data;
          CFG_STRENGTH_MAX: strength_max_r <= cfg_data;
          default: ;
        endcase
      end
      s1_valid_r  <= s1_valid_nxt;
      hunt_r      <= hunt_nxt;
      count_r     <= count_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_byte_r <= in_rx_byte;
    end
    if (store_byte) begin
      payload_r[count_r[1:0]] <= s1_byte_r;
    end
    if (frame_done) begin
      out_dist_r <= frame_dist;
      out_str_r  <= strength;
      out_mode_r <= s1_byte_r;
      out_ok_r   <= ok;
      out_held_r <= held_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_frame_distance    = out_dist_r;
  assign out_frame_strength    = out_str_r;
  assign out_range_mode        = out_mode_r;
  assign out_accepted          = out_ok_r;
  assign out_held_distance_out = out_held_r;

  // Outside a capture the payload counter rests at zero.
  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (hunt_r != HUNT_CAPTURE) |-> (count_r == '0))
    else $error("payload count nonzero outside capture");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LAST_CNT)
    else $error("payload count past last byte");

  // An accepted frame must report its own distance as the held one.
  a_held_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_accepted) |-> (out_held_distance_out == out_frame_distance))
    else $error("held distance differs from accepted distance");

  // The input side only stalls behind a waiting result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a waiting result");

  // A new result only follows a parsed byte.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || !out_stall) ##1 out_valid |-> $past(fire))
    else $error("result appeared without a parsed byte");

endmodule

// ===== test/lidar_frame_parser_tb.sv =====
`timescale 1ns / 1ps

module lidar_frame_parser_tb;
  import lfp_pkg::*;

  // Indexes outside the register map; writes to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam int PHASE_N     = 6;
  localparam int PHASE_ITEMS = 300;
  localparam int DIR_N       = 24;
  localparam int DRAIN_WAIT  = 20;

  // One completed frame as it leaves the out_ channel.
  typedef struct packed {
    logic [15:0] distance;
    logic [15:0] strength;
    logic [7:0]  mode;
    logic        accepted;
    logic [15:0] held;
  } frame_t;

  // Directed row: the byte, and for the mode byte of a frame whose result
  // is obvious, the result typed in by hand.
  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    frame_t     res;
  } dir_row_t;

  localparam frame_t NO_FRAME = '0;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_rx_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [15:0]           out_frame_distance;
  logic [15:0]           out_frame_strength;
  logic [7:0]            out_range_mode;
  logic                  out_accepted;
  logic [15:0]           out_held_distance_out;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  lidar_frame_parser uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_rx_byte            (in_rx_byte),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_frame_distance    (out_frame_distance),
    .out_frame_strength    (out_frame_strength),
    .out_range_mode        (out_range_mode),
    .out_accepted          (out_accepted),
    .out_held_distance_out (out_held_distance_out),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  always #1 clk = ~clk;

  // Directed stimulus under the reset bounds (20, 2000): a stray byte, a
  // clean frame, a broken header, a frame made only of header bytes, and a
  // frame at the field extremes with strength just above the lower bound.
  dir_row_t dir_tab [DIR_N] = '{
    '{8'h00, 1'b0, NO_FRAME},
    '{8'h59, 1'b0, NO_FRAME},
    '{8'h59, 1'b0, NO_FRAME},
    '{8'h34, 1'b0, NO_FRAME},
    '{8'h12, 1'b0, NO_FRAME},
    '{8'h64, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, NO_FRAME},
    '{8'h02, 1'b1, '{16'h1234, 16'd100, 8'd2, 1'b1, 16'h1234}},
    '{8'h59, 1'b0, NO_FRAME},
    '{8'hA6, 1'b0, NO_FRAME},
    '{8'h59, 1'b0, NO_FRAME},
    '{8'h59, 1'b0, NO_FRAME},
    '{8'h59, 1'b0, NO_FRAME},
    '{8'h59, 1'b0, NO_FRAME},
    '{8'h59, 1'b0, NO_FRAME},
    '{8'h59, 1'b0, NO_FRAME},
    '{8'h59, 1'b1, '{16'h5959, 16'h5959, 8'h59, 1'b0, 16'h1234}},
    '{8'h59, 1'b0, NO_FRAME},
    '{8'h59, 1'b0, NO_FRAME},
    '{8'hFF, 1'b0, NO_FRAME},
    '{8'hFF, 1'b0, NO_FRAME},
    '{8'h15, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, NO_FRAME},
    '{8'h07, 1'b1, '{16'hFFFF, 16'd21, 8'd7, 1'b1, 16'hFFFF}}
  };

  // Bound settings of the random phases: widest window, two windows that
  // let no strength through, a window letting exactly one strength through,
  // a random one, and back to the reset bounds.
  logic [15:0] phase_min [PHASE_N] = '{16'd0, 16'd0, 16'hFFFF, 16'd100, 16'd0, 16'd20};
  logic [15:0] phase_max [PHASE_N] = '{16'hFFFF, 16'd1, 16'hFFFF, 16'd102, 16'd0, 16'd2000};

  // Parser mirror: hunt state, payload capture, bounds and held distance.
  hunt_t       hunt = HUNT_IDLE;
  logic [2:0]  pay_cnt = '0;
  logic [7:0]  pay_buf [4] = '{default: 8'h00};
  logic [15:0] bound_lo = STRENGTH_MIN_RESET;
  logic [15:0] bound_hi = STRENGTH_MAX_RESET;
  logic [15:0] held_dist = '0;

  frame_t frames_due [$];

  int err_count    = 0;
  int bytes_sent   = 0;
  int frames_seen  = 0;
  int frames_taken = 0;
  int phase_items  = 0;
  bit in_burst     = 1'b0;
  bit out_burst    = 1'b0;
  int stall_left   = 0;

  // Advance the mirror by one byte; return 1 and the frame when it completes.
  function automatic bit parse_byte(input logic [7:0] rx, output frame_t res);
    bit          done;
    logic [15:0] dist_val;
    logic [15:0] str;
    done = 1'b0;
    res  = NO_FRAME;
    case (hunt)
      HUNT_CAPTURE: begin
        if (pay_cnt >= LAST_CNT) begin
          dist_val = {pay_buf[1], pay_buf[0]};
          str      = {pay_buf[3], pay_buf[2]};
          res.distance = dist_val;
          res.strength = str;
          res.mode     = rx;
          res.accepted = (str > bound_lo) && (str < bound_hi);
          if (res.accepted) held_dist = dist_val;
          res.held = held_dist;
          hunt     = HUNT_IDLE;
          pay_cnt  = '0;
          done     = 1'b1;
        end else begin
          pay_buf[pay_cnt[1:0]] = rx;
          pay_cnt = pay_cnt + 3'd1;
        end
      end
      HUNT_FIRST: begin
        // A bad second header drops to idle; the byte is not rechecked.
        if (rx == HDR_BYTE) begin
          hunt    = HUNT_CAPTURE;
          pay_cnt = '0;
        end else begin
          hunt = HUNT_IDLE;
        end
      end
      default: hunt = (rx == HDR_BYTE) ? HUNT_FIRST : HUNT_IDLE;
    endcase
    return done;
  endfunction

  // Drive one byte after a random gap, hold it until the transfer, then
  // queue the frame it completes (the typed one where given).
  task automatic send_byte(input logic [7:0] rx, input bit use_typed,
                           input frame_t typed_res);
    int     gap;
    frame_t res;
    if ($urandom_range(0, 63) == 0) in_burst = ~in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 15);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_rx_byte <= rx;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (parse_byte(rx, res)) begin
      if (use_typed) frames_due.push_back(typed_res);
      else frames_due.push_back(res);
    end else if (use_typed) begin
      frames_due.push_back(typed_res);
    end
  endtask

  // Random frame with a well-formed header; strength leans on the bounds.
  task automatic send_frame();
    logic [15:0] dist_val;
    logic [15:0] str;
    logic [7:0]  mode;
    dist_val = 16'($urandom);
    case ($urandom_range(0, 6))
      0: str = 16'($urandom);
      1: str = bound_lo;
      2: str = bound_lo + 16'd1;
      3: str = bound_hi - 16'd1;
      4: str = bound_hi;
      5: str = (bound_hi > bound_lo + 16'd1) ?
               bound_lo + 16'd1 + 16'($urandom % (bound_hi - bound_lo - 16'd1)) :
               16'($urandom);
      default: str = 16'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 2))
      0: mode = 8'd2;
      1: mode = 8'd7;
      default: mode = 8'($urandom);
    endcase
    send_byte(HDR_BYTE, 1'b0, NO_FRAME);
    send_byte(HDR_BYTE, 1'b0, NO_FRAME);
    send_byte(dist_val[7:0], 1'b0, NO_FRAME);
    send_byte(dist_val[15:8], 1'b0, NO_FRAME);
    send_byte(str[7:0], 1'b0, NO_FRAME);
    send_byte(str[15:8], 1'b0, NO_FRAME);
    send_byte(mode, 1'b0, NO_FRAME);
    phase_items += 7;
  endtask

  // Stray bytes, broken headers and cut-off frames; only cut-off frames are counted.
  task automatic send_noise();
    int n;
    case ($urandom_range(0, 2))
      0: send_byte(8'($urandom), 1'b0, NO_FRAME);
      1: begin
        send_byte(HDR_BYTE, 1'b0, NO_FRAME);
        send_byte(8'($urandom_range(0, 255)) ^ 8'h01, 1'b0, NO_FRAME);
      end
      default: begin
        n = $urandom_range(0, 4);
        send_byte(HDR_BYTE, 1'b0, NO_FRAME);
        send_byte(HDR_BYTE, 1'b0, NO_FRAME);
        repeat (n) send_byte(8'($urandom), 1'b0, NO_FRAME);
        phase_items += 2 + n;
      end
    endcase
  endtask

  // Write one register at the next falling edge and mirror it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_STRENGTH_MIN) bound_lo = val;
    else if (idx == CFG_STRENGTH_MAX) bound_hi = val;
  endtask

  // Wait for every queued frame, then let any byte still in the pipe settle.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Receiver stall: count down the cycles drawn at the last transfer.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check each result transfer against the oldest queued frame.
  always @(posedge clk) begin : result_check
    frame_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (frames_due.size() == 0) begin
        $error("unexpected result: distance %h strength %h", out_frame_distance,
               out_frame_strength);
        err_count++;
      end else begin
        want = frames_due.pop_front();
        frames_seen++;
        if (want.accepted) frames_taken++;
        if (out_frame_distance !== want.distance) begin
          $error("frame_distance: expected %h, got %h", want.distance, out_frame_distance);
          err_count++;
        end
        if (out_frame_strength !== want.strength) begin
          $error("frame_strength: expected %h, got %h", want.strength, out_frame_strength);
          err_count++;
        end
        if (out_range_mode !== want.mode) begin
          $error("range_mode: expected %h, got %h", want.mode, out_range_mode);
          err_count++;
        end
        if (out_accepted !== want.accepted) begin
          $error("accepted: expected %b, got %b", want.accepted, out_accepted);
          err_count++;
        end
        if (out_held_distance_out !== want.held) begin
          $error("held_distance_out: expected %h, got %h", want.held, out_held_distance_out);
          err_count++;
        end
      end
      if ($urandom_range(0, 31) == 0) out_burst = ~out_burst;
      stall_left = out_burst ? 0 : $urandom_range(0, 15);
    end
  end

  initial begin
    logic [15:0] lo;
    logic [15:0] hi;
    // Hold reset, then release at a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table under the reset bounds.
    for (int i = 0; i < DIR_N; i++) begin
      send_byte(dir_tab[i].rx, dir_tab[i].typed, dir_tab[i].res);
    end

    for (int p = 0; p < PHASE_N; p++) begin
      wait_idle();
      lo = phase_min[p];
      hi = phase_max[p];
      if (p == 4) begin
        lo = 16'($urandom_range(0, 30000));
        hi = lo + 16'($urandom_range(2, 30000));
      end
      write_reg(CFG_STRENGTH_MIN, lo);
      write_reg(CFG_STRENGTH_MAX, hi);
      // Hit the unmapped indexes; the bounds must not move.
      write_reg(CFG_SPARE_A, 16'($urandom));
      write_reg(CFG_SPARE_B, 16'($urandom));
      @(negedge clk);
      cfg_wr_en <= 1'b0;

      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 85) send_frame();
        else send_noise();
      end
    end

    // Drain: drop valid, wait for the last frames, then let the pipe settle.
    @(negedge clk);
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (frames_due.size() != 0) err_count++;

    $display("Sent %0d bytes over %0d bound settings; %0d frames checked, %0d accepted.",
             bytes_sent, PHASE_N + 1, frames_seen, frames_taken);
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
